[rtl/winding_angle_point_in_polygon_assert.svh]
// ----------------------------------------------------------------------------
// Winding-angle point-in-polygon: assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef WINDING_ANGLE_POINT_IN_POLYGON_ASSERT_SVH
`define WINDING_ANGLE_POINT_IN_POLYGON_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define WAPIP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define WAPIP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/wapip_pkg.sv]
// ----------------------------------------------------------------------------
// Winding-angle point-in-polygon: package
// Payload types, stage data types, fixed widths and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
`default_nettype none

package wapip_pkg;

  // Defaults for the top-level parameters.
  localparam int ANGLE_BITS_DEF    = 16;
  localparam int COORD_BITS_DEF    = 32;
  localparam int CORDIC_STAGES_DEF = 16;

  // Fixed field and state widths.
  localparam int FIELD_BITS = 32;
  localparam int SUM_BITS   = 32;
  localparam int TURN_BITS  = 16;

  // Offsets are normalized so that the larger magnitude lands in [2^52, 2^53).
  localparam int NORM_BITS  = 53;
  localparam int NORM_STEPS = 6;
  // CORDIC datapath width covers the gain growth of the normalized vector.
  localparam int CW         = 57;
  // Angle accumulator in units of 2^-32 turn.
  localparam int Z_BITS     = 32;

  typedef struct packed {
    logic signed [FIELD_BITS-1:0] point_x;
    logic signed [FIELD_BITS-1:0] point_y;
    logic signed [FIELD_BITS-1:0] vertex_x;
    logic signed [FIELD_BITS-1:0] vertex_y;
    logic                         first_vertex;
    logic                         last_vertex;
  } wapip_in_t;

  typedef struct packed {
    logic                        is_inside;
    logic signed [TURN_BITS-1:0] winding_turns;
  } wapip_out_t;

  // Per-vertex flags that ride along the pipeline.
  typedef struct packed {
    logic first;
    logic last;
    logic zero;
    logic dx_neg;
    logic dy_neg;
  } wapip_tag_t;

  typedef struct packed {
    wapip_tag_t           tag;
    logic [NORM_BITS-1:0] ax;
    logic [NORM_BITS-1:0] ay;
  } wapip_norm_t;

  typedef struct packed {
    wapip_tag_t               tag;
    logic signed [CW-1:0]     x;
    logic signed [CW-1:0]     y;
    logic signed [Z_BITS-1:0] z;
  } wapip_rot_t;

  // atan(2^-i) in units of 2^-32 turn.
  function automatic logic signed [Z_BITS-1:0] atan_turns(input int idx);
    logic signed [Z_BITS-1:0] v;
    unique case (idx)
      0:       v = 32'sd536870912;
      1:       v = 32'sd316933406;
      2:       v = 32'sd167458907;
      3:       v = 32'sd85004756;
      4:       v = 32'sd42667331;
      5:       v = 32'sd21354465;
      6:       v = 32'sd10679838;
      7:       v = 32'sd5340245;
      8:       v = 32'sd2670163;
      9:       v = 32'sd1335087;
      10:      v = 32'sd667544;
      11:      v = 32'sd333772;
      12:      v = 32'sd166886;
      13:      v = 32'sd83443;
      14:      v = 32'sd41722;
      15:      v = 32'sd20861;
      16:      v = 32'sd10430;
      17:      v = 32'sd5215;
      18:      v = 32'sd2608;
      19:      v = 32'sd1304;
      20:      v = 32'sd652;
      21:      v = 32'sd326;
      22:      v = 32'sd163;
      23:      v = 32'sd81;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

[rtl/wapip_norm_cell.sv]
// ----------------------------------------------------------------------------
// Winding-angle point-in-polygon: normalize cell
// One step of the left-justify chain: shifts both magnitudes by SHIFT when the
// top SHIFT bits of the larger one are clear.
// ----------------------------------------------------------------------------
`default_nettype none

module wapip_norm_cell
  import wapip_pkg::*;
#(
  parameter int SHIFT = 1
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        adv,
  input  wire logic        din_valid,
  input  wire wapip_norm_t din,
  output logic             dout_valid,
  output wapip_norm_t      dout
);

  logic                 valid_r;
  wapip_norm_t          data_r;
  wapip_norm_t          data_nxt;
  logic [NORM_BITS-1:0] mag_or;

  // OR of both magnitudes has the same leading one as the larger of the two.
  always_comb begin
    mag_or   = din.ax | din.ay;
    data_nxt = din;
    if (mag_or[NORM_BITS-1 -: SHIFT] == '0) begin
      data_nxt.ax = din.ax << SHIFT;
      data_nxt.ay = din.ay << SHIFT;
    end
  end

  // Stage valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= din_valid;
    end
  end

  // Stage data.
  always_ff @(posedge clk) begin
    if (adv) begin
      data_r <= data_nxt;
    end
  end

  assign dout_valid = valid_r;
  assign dout       = data_r;

endmodule

`default_nettype wire

[rtl/wapip_cordic_cell.sv]
// ----------------------------------------------------------------------------
// Winding-angle point-in-polygon: CORDIC cell
// One vectoring micro-rotation: drives y toward zero and accumulates the
// rotation angle in z.
// ----------------------------------------------------------------------------
`default_nettype none

module wapip_cordic_cell
  import wapip_pkg::*;
#(
  parameter int STAGE = 0
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       adv,
  input  wire logic       din_valid,
  input  wire wapip_rot_t din,
  output logic            dout_valid,
  output wapip_rot_t      dout
);

  localparam logic signed [Z_BITS-1:0] ATAN = atan_turns(STAGE);

  logic                 valid_r;
  wapip_rot_t           data_r;
  wapip_rot_t           data_nxt;
  logic signed [CW-1:0] xs;
  logic signed [CW-1:0] ys;

  // Rotate toward the x axis; direction follows the sign of y.
  always_comb begin
    xs       = $signed(din.x) >>> STAGE;
    ys       = $signed(din.y) >>> STAGE;
    data_nxt = din;
    if (!din.y[CW-1]) begin
      data_nxt.x = $signed(din.x) + ys;
      data_nxt.y = $signed(din.y) - xs;
      data_nxt.z = $signed(din.z) + ATAN;
    end else begin
      data_nxt.x = $signed(din.x) - ys;
      data_nxt.y = $signed(din.y) + xs;
      data_nxt.z = $signed(din.z) - ATAN;
    end
  end

  // Stage valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= din_valid;
    end
  end

  // Stage data.
  always_ff @(posedge clk) begin
    if (adv) begin
      data_r <= data_nxt;
    end
  end

  assign dout_valid = valid_r;
  assign dout       = data_r;

endmodule

`default_nettype wire

[rtl/wapip_accum.sv]
// ----------------------------------------------------------------------------
// Winding-angle point-in-polygon: accumulator
// Rounds the CORDIC angle to a bearing, wraps the change from the previous
// bearing, keeps the saturating angle sum and formats the result beat.
// ----------------------------------------------------------------------------
`default_nettype none

`include "winding_angle_point_in_polygon_assert.svh"

module wapip_accum
  import wapip_pkg::*;
#(
  parameter int ANGLE_BITS = ANGLE_BITS_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       adv,
  input  wire logic       rot_valid,
  input  wire wapip_rot_t rot,
  input  wire logic       out_ready,
  output logic            hold,
  output logic            out_valid,
  output wapip_out_t      out_data
);

  localparam int SW1 = SUM_BITS + 1;

  localparam logic [Z_BITS-1:0]     RND     = Z_BITS'(1) << (Z_BITS - 1 - ANGLE_BITS);
  localparam logic [ANGLE_BITS-1:0] QUARTER = ANGLE_BITS'(1) << (ANGLE_BITS - 2);
  localparam logic [ANGLE_BITS-1:0] HALF    = ANGLE_BITS'(1) << (ANGLE_BITS - 1);

  localparam logic signed [ANGLE_BITS+1:0] HALF_D = (ANGLE_BITS + 2)'(1) << (ANGLE_BITS - 1);
  localparam logic signed [ANGLE_BITS+1:0] FULL_D = (ANGLE_BITS + 2)'(1) << ANGLE_BITS;
  localparam logic signed [ANGLE_BITS:0]   HALF_W = (ANGLE_BITS + 1)'(1) << (ANGLE_BITS - 1);

  localparam logic signed [SUM_BITS-1:0] FULL_SUM = SUM_BITS'(1) << ANGLE_BITS;
  localparam logic signed [SUM_BITS-1:0] NEG_FULL = -FULL_SUM;
  localparam logic signed [SUM_BITS-1:0] SUM_MAX  = {1'b0, {(SUM_BITS - 1){1'b1}}};
  localparam logic signed [SUM_BITS-1:0] SUM_MIN  = {1'b1, {(SUM_BITS - 1){1'b0}}};

  localparam logic signed [SW1-1:0] HALF_S = SW1'(1) << (ANGLE_BITS - 1);
  localparam logic signed [SW1-1:0] T_MAX  = SW1'((1 << (TURN_BITS - 1)) - 1);
  localparam logic signed [SW1-1:0] T_MIN  = -T_MAX - SW1'(1);

  // Bearing stage.
  logic                  b_valid_r;
  wapip_tag_t            b_tag_r;
  logic [ANGLE_BITS-1:0] b_r;
  logic [ANGLE_BITS-1:0] b_nxt;
  logic [Z_BITS-2:0]     z_clip;
  logic [Z_BITS-1:0]     z_rnd;
  logic [ANGLE_BITS-1:0] t_raw;
  logic [ANGLE_BITS-1:0] t_q;

  // Wrap stage.
  logic                    d_valid_r;
  wapip_tag_t              d_tag_r;
  logic signed [ANGLE_BITS:0]   d_r;
  logic signed [ANGLE_BITS:0]   d_nxt;
  logic signed [ANGLE_BITS+1:0] d_raw;
  logic signed [ANGLE_BITS+1:0] d_wrap;
  logic [ANGLE_BITS-1:0]        prev_r;

  // Sum stage.
  logic                       sum_valid_r;
  logic                       sum_first_r;
  logic                       sum_last_r;
  logic signed [SUM_BITS-1:0] sum_r;
  logic signed [SUM_BITS-1:0] sum_nxt;
  logic signed [SW1-1:0]      sum_ext;
  logic                       rep;

  // Output register.
  logic                  out_valid_r;
  wapip_out_t            out_data_r;
  wapip_out_t            out_nxt;
  logic signed [SW1-1:0] rnd_sum;
  logic signed [SW1-1:0] turns_raw;

  // Round the first-quadrant angle and map it to its true quadrant.
  always_comb begin
    z_clip = rot.z[Z_BITS-1] ? '0 : rot.z[Z_BITS-2:0];
    z_rnd  = {1'b0, z_clip} + RND;
    t_raw  = z_rnd[Z_BITS-1 -: ANGLE_BITS];
    t_q    = (t_raw > QUARTER) ? QUARTER : t_raw;
    if (rot.tag.zero) begin
      b_nxt = QUARTER;
    end else if (!rot.tag.dx_neg) begin
      b_nxt = rot.tag.dy_neg ? (HALF - t_q) : t_q;
    end else begin
      b_nxt = rot.tag.dy_neg ? (HALF + t_q) : ('0 - t_q);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else if (adv) begin
      b_valid_r <= rot_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b_r     <= b_nxt;
      b_tag_r <= rot.tag;
    end
  end

  // Bearing change, wrapped into a half turn either way.
  always_comb begin
    d_raw = $signed({2'b00, b_r}) - $signed({2'b00, prev_r});
    if (d_raw > HALF_D) begin
      d_wrap = d_raw - FULL_D;
    end else if (d_raw < -HALF_D) begin
      d_wrap = d_raw + FULL_D;
    end else begin
      d_wrap = d_raw;
    end
    d_nxt = d_wrap[ANGLE_BITS:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_valid_r <= 1'b0;
      prev_r    <= '0;
    end else if (adv) begin
      d_valid_r <= b_valid_r;
      if (b_valid_r) begin
        prev_r <= b_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d_r     <= d_nxt;
      d_tag_r <= b_tag_r;
    end
  end

  // Running sum, restarted by a first vertex and saturated to 32 bits.
  always_comb begin
    sum_ext = $signed({sum_r[SUM_BITS-1], sum_r}) + SW1'(d_r);
    if (d_tag_r.first) begin
      sum_nxt = '0;
    end else if (sum_ext[SW1-1] != sum_ext[SW1-2]) begin
      sum_nxt = sum_ext[SW1-1] ? SUM_MIN : SUM_MAX;
    end else begin
      sum_nxt = sum_ext[SUM_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_valid_r <= 1'b0;
      sum_r       <= '0;
    end else if (adv) begin
      sum_valid_r <= d_valid_r;
      if (d_valid_r) begin
        sum_r <= sum_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sum_first_r <= d_tag_r.first;
      sum_last_r  <= d_tag_r.last;
    end
  end

  assign rep  = sum_valid_r && sum_last_r;
  // A finished polygon cannot move on while the previous result is unread.
  assign hold = out_valid_r && !out_ready && rep;

  // Result formatting: nearest whole turn, halves upward, saturated.
  always_comb begin
    rnd_sum   = $signed({sum_r[SUM_BITS-1], sum_r}) + HALF_S;
    turns_raw = rnd_sum >>> ANGLE_BITS;
    out_nxt.is_inside = (sum_r == FULL_SUM) || (sum_r == NEG_FULL);
    if (turns_raw > T_MAX) begin
      out_nxt.winding_turns = T_MAX[TURN_BITS-1:0];
    end else if (turns_raw < T_MIN) begin
      out_nxt.winding_turns = T_MIN[TURN_BITS-1:0];
    end else begin
      out_nxt.winding_turns = turns_raw[TURN_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv && rep) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && rep) begin
      out_data_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // A stalled report stays in place until the result register frees up.
  `WAPIP_ASSERT_NEXT(a_hold_keeps_report, hold, rep, "stalled report was lost")
  // A coincident vertex always yields a quarter-turn bearing.
  `WAPIP_ASSERT_NOW(a_zero_quarter, b_valid_r && b_tag_r.zero,
                    b_r == QUARTER, "zero offset bearing")
  // Wrapped bearing changes never exceed a half turn.
  `WAPIP_ASSERT_NOW(a_wrap_range, d_valid_r,
                    (d_r <= HALF_W) && (d_r >= -HALF_W), "wrap range")
  // A first vertex clears the sum.
  `WAPIP_ASSERT_NOW(a_first_clears, sum_valid_r && sum_first_r, sum_r == '0, "sum not cleared")
  // Inside means exactly one turn either way.
  `WAPIP_ASSERT_NOW(a_inside_turns, out_valid_r && out_data_r.is_inside,
                    (out_data_r.winding_turns == 16'sd1) ||
                    (out_data_r.winding_turns == -16'sd1), "inside but turns not one")

endmodule

`default_nettype wire

[rtl/winding_angle_point_in_polygon.sv]
// Throughput: one vertex beat per cycle; the chain of normalize and CORDIC cells
// is fully pipelined and the sum is updated once per vertex.
// The chain stalls only while a finished result waits and another one is due.
// Reset clears all stage valids, the held point, the previous bearing and the sum.
// ----------------------------------------------------------------------------
// Winding-angle point-in-polygon: top level
// Streams polygon vertices, computes each bearing from the test point by a
// chain of CORDIC cells and reports the net winding after the last vertex.
// ----------------------------------------------------------------------------
`default_nettype none

module winding_angle_point_in_polygon
  import wapip_pkg::*;
#(
  parameter int ANGLE_BITS    = ANGLE_BITS_DEF,
  parameter int COORD_BITS    = COORD_BITS_DEF,
  parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire wapip_in_t in_data,
  output logic           out_valid,
  input  wire logic      out_ready,
  output wapip_out_t     out_data
);

  localparam int DW = COORD_BITS + 1;

  logic adv;
  logic hold;
  logic accept;

  // Coordinates read at the configured width.
  logic signed [COORD_BITS-1:0] px_in;
  logic signed [COORD_BITS-1:0] py_in;
  logic signed [COORD_BITS-1:0] vx_in;
  logic signed [COORD_BITS-1:0] vy_in;
  logic signed [COORD_BITS-1:0] px_sel;
  logic signed [COORD_BITS-1:0] py_sel;
  logic signed [COORD_BITS-1:0] held_px_r;
  logic signed [COORD_BITS-1:0] held_py_r;

  // Offset stage.
  logic                 s0_valid_r;
  logic signed [DW-1:0] s0_dx_r;
  logic signed [DW-1:0] s0_dy_r;
  logic                 s0_first_r;
  logic                 s0_last_r;

  // Magnitude stage.
  logic [DW-1:0] ax;
  logic [DW-1:0] ay;
  logic          s1_valid_r;
  wapip_norm_t   s1_nxt;
  wapip_norm_t   s1_r;

  wapip_norm_t norm_d [0:NORM_STEPS];
  logic        norm_v [0:NORM_STEPS];
  wapip_rot_t  rot_d  [0:CORDIC_STAGES];
  logic        rot_v  [0:CORDIC_STAGES];

  assign adv      = !hold;
  assign in_ready = adv;
  assign accept   = in_valid && adv;

  generate
    if (COORD_BITS <= FIELD_BITS) begin : g_narrow
      assign px_in = in_data.point_x[COORD_BITS-1:0];
      assign py_in = in_data.point_y[COORD_BITS-1:0];
      assign vx_in = in_data.vertex_x[COORD_BITS-1:0];
      assign vy_in = in_data.vertex_y[COORD_BITS-1:0];
    end else begin : g_wide
      assign px_in = {{(COORD_BITS - FIELD_BITS){1'b0}}, in_data.point_x};
      assign py_in = {{(COORD_BITS - FIELD_BITS){1'b0}}, in_data.point_y};
      assign vx_in = {{(COORD_BITS - FIELD_BITS){1'b0}}, in_data.vertex_x};
      assign vy_in = {{(COORD_BITS - FIELD_BITS){1'b0}}, in_data.vertex_y};
    end
  endgenerate

  // A first vertex brings its own test point.
  assign px_sel = in_data.first_vertex ? px_in : held_px_r;
  assign py_sel = in_data.first_vertex ? py_in : held_py_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_px_r <= '0;
      held_py_r <= '0;
    end else if (accept && in_data.first_vertex) begin
      held_px_r <= px_in;
      held_py_r <= py_in;
    end
  end

  // Offset of the vertex from the test point.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
    end else if (adv) begin
      s0_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s0_dx_r    <= {vx_in[COORD_BITS-1], vx_in} - {px_sel[COORD_BITS-1], px_sel};
      s0_dy_r    <= {vy_in[COORD_BITS-1], vy_in} - {py_sel[COORD_BITS-1], py_sel};
      s0_first_r <= in_data.first_vertex;
      s0_last_r  <= in_data.last_vertex;
    end
  end

  // Magnitudes and quadrant flags.
  always_comb begin
    ax = s0_dx_r[DW-1] ? (DW'(0) - s0_dx_r) : s0_dx_r;
    ay = s0_dy_r[DW-1] ? (DW'(0) - s0_dy_r) : s0_dy_r;
    s1_nxt.tag.first  = s0_first_r;
    s1_nxt.tag.last   = s0_last_r;
    s1_nxt.tag.zero   = (s0_dx_r == '0) && (s0_dy_r == '0);
    s1_nxt.tag.dx_neg = s0_dx_r[DW-1];
    s1_nxt.tag.dy_neg = s0_dy_r[DW-1];
    s1_nxt.ax         = NORM_BITS'(ax);
    s1_nxt.ay         = NORM_BITS'(ay);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r <= s0_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_r <= s1_nxt;
    end
  end

  // Left-justify chain, largest shift first.
  assign norm_d[0] = s1_r;
  assign norm_v[0] = s1_valid_r;

  generate
    for (genvar j = 0; j < NORM_STEPS; j++) begin : g_norm
      wapip_norm_cell #(
        .SHIFT(1 << (NORM_STEPS - 1 - j))
      ) u_norm (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .din_valid (norm_v[j]),
        .din       (norm_d[j]),
        .dout_valid(norm_v[j+1]),
        .dout      (norm_d[j+1])
      );
    end
  endgenerate

  // Vector starts as (|dy|, |dx|) so the angle is measured from the y axis.
  assign rot_v[0]     = norm_v[NORM_STEPS];
  assign rot_d[0].tag = norm_d[NORM_STEPS].tag;
  assign rot_d[0].x   = $signed({{(CW - NORM_BITS){1'b0}}, norm_d[NORM_STEPS].ay});
  assign rot_d[0].y   = $signed({{(CW - NORM_BITS){1'b0}}, norm_d[NORM_STEPS].ax});
  assign rot_d[0].z   = '0;

  generate
    for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
      wapip_cordic_cell #(
        .STAGE(i)
      ) u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .din_valid (rot_v[i]),
        .din       (rot_d[i]),
        .dout_valid(rot_v[i+1]),
        .dout      (rot_d[i+1])
      );
    end
  endgenerate

  wapip_accum #(
    .ANGLE_BITS(ANGLE_BITS)
  ) u_accum (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .rot_valid(rot_v[CORDIC_STAGES]),
    .rot      (rot_d[CORDIC_STAGES]),
    .out_ready(out_ready),
    .hold     (hold),
    .out_valid(out_valid),
    .out_data (out_data)
  );

endmodule

`default_nettype wire

[tb/sv/testbench.sv]
// ----------------------------------------------------------------------------
// Winding-angle point-in-polygon: testbench
// Streams directed and random polygons into the block under random sender and
// receiver pacing. A scoreboard class predicts each vertex bearing by its own
// CORDIC and the running winding sum, and checks every result beat in order.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
  import wapip_pkg::*;

  // Geometry of the prediction, at the block's default parameters.
  localparam int     BEARING_BITS  = ANGLE_BITS_DEF;
  localparam int     STAGE_COUNT   = CORDIC_STAGES_DEF;
  localparam int     ATAN_ENTRIES  = 24;
  localparam longint FULL_TURN     = 64'sd1 <<< BEARING_BITS;
  localparam longint HALF_TURN     = FULL_TURN >>> 1;
  localparam longint QUARTER_TURN  = FULL_TURN >>> 2;
  localparam longint NORM_FLOOR    = 64'sd1 <<< 52;
  localparam longint SUM_MAX       = 64'sd2147483647;
  localparam longint SUM_MIN       = -64'sd2147483648;
  localparam longint TURNS_MAX     = 64'sd32767;
  localparam longint TURNS_MIN     = -64'sd32768;

  // Run control.
  localparam int     RESET_CYCLES  = 7;
  localparam int     RANDOM_BEATS  = 1200;
  localparam int     MIN_RINGS     = 48;
  localparam int     SPIRAL_TURNS  = 6;
  localparam int     REPORT_LIMIT  = 10;
  localparam int     IDLE_LIMIT    = 2000;
  localparam int     DRAIN_CYCLES  = 64;
  localparam real    TWO_PI        = 6.283185307179586;

  localparam logic signed [31:0] COORD_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] COORD_MAX = 32'sh7FFF_FFFF;

  typedef enum int {
    READY_ALWAYS,
    READY_COIN,
    READY_SPARSE,
    READY_PERIODIC
  } ready_mode_t;

  typedef enum int {
    PT_INSIDE,
    PT_OUTSIDE,
    PT_ON_VERTEX,
    PT_ON_EDGE
  } point_place_t;

  // Predicts the winding verdict of each polygon and checks the result beats.
  class winding_scoreboard;
    wapip_out_t              verdict_q[$];
    longint                  held_x;
    longint                  held_y;
    longint                  angle_total;
    logic [BEARING_BITS-1:0] last_bearing;
    longint                  atan_step[ATAN_ENTRIES];
    int                      faults;
    int                      verdicts_checked;
    int                      inside_count;
    int                      vertices_noted;
    int                      polygons_started;

    function new();
      atan_step = '{536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
                    10679838, 5340245, 2670163, 1335087, 667544, 333772,
                    166886, 83443, 41722, 20861, 10430, 5215,
                    2608, 1304, 652, 326, 163, 81};
      held_x = 0;
      held_y = 0;
      angle_total = 0;
      last_bearing = '0;
      faults = 0;
      verdicts_checked = 0;
      inside_count = 0;
      vertices_noted = 0;
      polygons_started = 0;
    endfunction

    // Bearing of an offset from the +y axis toward +x, as a binary angle.
    function logic [BEARING_BITS-1:0] vertex_bearing(longint dx, longint dy);
      longint ax, ay, span, x, y, z, xs, ys, t, b;
      if (dx == 0 && dy == 0) begin
        return BEARING_BITS'(QUARTER_TURN);
      end
      ax = (dx < 0) ? -dx : dx;
      ay = (dy < 0) ? -dy : dy;
      span = (ax > ay) ? ax : ay;
      // Scale both magnitudes together until the larger one reaches 2^52.
      while (span < NORM_FLOOR) begin
        ax = ax <<< 1;
        ay = ay <<< 1;
        span = span <<< 1;
      end
      // Vectoring CORDIC in the first quadrant, angle in 2^-32 turn.
      x = ay;
      y = ax;
      z = 0;
      for (int i = 0; i < STAGE_COUNT && i < ATAN_ENTRIES; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (y >= 0) begin
          x = x + ys;
          y = y - xs;
          z = z + atan_step[i];
        end else begin
          x = x - ys;
          y = y + xs;
          z = z - atan_step[i];
        end
      end
      if (z < 0) z = 0;
      t = (z + (64'sd1 <<< (31 - BEARING_BITS))) >>> (32 - BEARING_BITS);
      if (t > QUARTER_TURN) t = QUARTER_TURN;
      // Map back to the true quadrant; a zero x offset counts as positive x.
      if (dx >= 0) begin
        b = (dy >= 0) ? t : HALF_TURN - t;
      end else begin
        b = (dy < 0) ? HALF_TURN + t : FULL_TURN - t;
      end
      return BEARING_BITS'(b & (FULL_TURN - 1));
    endfunction

    // Folds one accepted vertex beat into the sum and queues a verdict on a last vertex.
    function void note_vertex(wapip_in_t beat);
      logic [BEARING_BITS-1:0] b;
      longint                  delta;
      longint                  turns;
      wapip_out_t              want;
      vertices_noted++;
      if (beat.first_vertex) begin
        held_x = longint'(signed'(beat.point_x));
        held_y = longint'(signed'(beat.point_y));
        polygons_started++;
      end
      b = vertex_bearing(longint'(signed'(beat.vertex_x)) - held_x,
                         longint'(signed'(beat.vertex_y)) - held_y);
      if (beat.first_vertex) begin
        angle_total = 0;
      end else begin
        // A change of exactly a half turn keeps its sign.
        delta = longint'(b) - longint'(last_bearing);
        if (delta > HALF_TURN) delta = delta - FULL_TURN;
        if (delta < -HALF_TURN) delta = delta + FULL_TURN;
        angle_total = angle_total + delta;
        if (angle_total > SUM_MAX) angle_total = SUM_MAX;
        if (angle_total < SUM_MIN) angle_total = SUM_MIN;
      end
      last_bearing = b;
      if (beat.last_vertex) begin
        turns = (angle_total + HALF_TURN) >>> BEARING_BITS;
        if (turns > TURNS_MAX) turns = TURNS_MAX;
        if (turns < TURNS_MIN) turns = TURNS_MIN;
        want.is_inside = (angle_total == FULL_TURN || angle_total == -FULL_TURN);
        want.winding_turns = turns[TURN_BITS-1:0];
        verdict_q.push_back(want);
      end
    endfunction

    // Compares one result beat with the oldest queued verdict.
    function void check_verdict(wapip_out_t got);
      wapip_out_t want;
      if (verdict_q.size() == 0) begin
        faults++;
        if (faults <= REPORT_LIMIT) begin
          $display("ERROR: result beat with no verdict pending: inside=%0d turns=%0d",
                   got.is_inside, got.winding_turns);
        end
        return;
      end
      want = verdict_q.pop_front();
      verdicts_checked++;
      if (want.is_inside) inside_count++;
      if (got.is_inside !== want.is_inside || got.winding_turns !== want.winding_turns) begin
        faults++;
        if (faults <= REPORT_LIMIT) begin
          $display("ERROR: verdict %0d: inside exp %0d got %0d, turns exp %0d got %0d",
                   verdicts_checked, want.is_inside, got.is_inside,
                   want.winding_turns, got.winding_turns);
        end
      end
    endfunction

    function int pending();
      return verdict_q.size();
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  wapip_in_t  in_data = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  wapip_out_t out_data;

  wapip_in_t         vertex_q[$];
  winding_scoreboard sb;
  int                total_beats;
  int                accepted_beats = 0;
  int                idle_cycles = 0;
  int                rings_made = 0;

  winding_angle_point_in_polygon u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #5 clk = ~clk;

  // Random real in [0, 1).
  function automatic real unit_rand();
    return real'($urandom_range(0, 999999)) / 1000000.0;
  endfunction

  // Rounds a real coordinate and clamps it to the 32-bit field range.
  function automatic logic signed [31:0] to_coord(input real v);
    longint w;
    if (v > 2147483647.0) v = 2147483647.0;
    if (v < -2147483648.0) v = -2147483648.0;
    w = longint'(v);
    return w[31:0];
  endfunction

  task automatic push_vertex(input logic signed [31:0] px, input logic signed [31:0] py,
                             input logic signed [31:0] vx, input logic signed [31:0] vy,
                             input logic first, input logic last);
    wapip_in_t beat;
    beat.point_x = px;
    beat.point_y = py;
    beat.vertex_x = vx;
    beat.vertex_y = vy;
    beat.first_vertex = first;
    beat.last_vertex = last;
    vertex_q.push_back(beat);
  endtask

  // Queues a ring of vertices around a center, n per turn, with a test point
  // placed inside, outside, on a vertex or on an edge.
  task automatic add_ring(input real cx, input real cy, input real r, input int n,
                          input int turns, input int dir, input point_place_t place,
                          input bit closed);
    logic signed [31:0] ring_x[$];
    logic signed [31:0] ring_y[$];
    logic signed [31:0] px, py;
    real                base, th, rr, phi;
    int                 total;
    total = n * turns;
    base = TWO_PI * unit_rand();
    for (int k = 0; k < total; k++) begin
      th = base + dir * TWO_PI * k / n + (unit_rand() - 0.5) * 0.4 * TWO_PI / n;
      rr = r * (0.6 + 0.4 * unit_rand());
      ring_x.push_back(to_coord(cx + rr * $sin(th)));
      ring_y.push_back(to_coord(cy + rr * $cos(th)));
    end
    phi = TWO_PI * unit_rand();
    case (place)
      PT_INSIDE: begin
        px = to_coord(cx + 0.2 * r * unit_rand() * $sin(phi));
        py = to_coord(cy + 0.2 * r * unit_rand() * $cos(phi));
      end
      PT_OUTSIDE: begin
        px = to_coord(cx + 3.0 * r * $sin(phi));
        py = to_coord(cy + 3.0 * r * $cos(phi));
      end
      PT_ON_VERTEX: begin
        px = ring_x[0];
        py = ring_y[0];
      end
      default: begin
        px = to_coord((real'(ring_x[0]) + real'(ring_x[1])) / 2.0);
        py = to_coord((real'(ring_y[0]) + real'(ring_y[1])) / 2.0);
      end
    endcase
    push_vertex(px, py, ring_x[0], ring_y[0], 1'b1, total == 1 && !closed);
    // Later beats carry junk in the point fields; only the first latches it.
    for (int k = 1; k < total; k++) begin
      push_vertex($urandom(), $urandom(), ring_x[k], ring_y[k], 1'b0,
                  k == total - 1 && !closed);
    end
    if (closed) push_vertex($urandom(), $urandom(), ring_x[0], ring_y[0], 1'b0, 1'b1);
  endtask

  // Sender: bursts of random length separated by random gaps.
  task automatic drive_vertices();
    int burst_left;
    int gap_left;
    burst_left = 0;
    gap_left = 0;
    forever begin
      @(posedge clk);
      if (rst_n && (!in_valid || in_ready)) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (vertex_q.size() > 0) begin
          in_data <= vertex_q.pop_front();
          in_valid <= 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 31);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 16);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  endtask

  // Receiver: windows of random length, each with its own stall pattern.
  task automatic pace_results();
    ready_mode_t mode;
    int          left;
    mode = READY_ALWAYS;
    left = 0;
    forever begin
      @(posedge clk);
      if (left == 0) begin
        mode = ready_mode_t'($urandom_range(0, 3));
        left = $urandom_range(16, 96);
      end
      left--;
      case (mode)
        READY_ALWAYS: out_ready <= 1'b1;
        READY_COIN:   out_ready <= 1'($urandom_range(0, 1));
        READY_SPARSE: out_ready <= ($urandom_range(0, 7) == 0);
        default:      out_ready <= (left % 5 == 0);
      endcase
    end
  endtask

  initial drive_vertices();
  initial pace_results();

  // Monitor: every accepted beat goes to the scoreboard.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        sb.note_vertex(in_data);
        accepted_beats++;
      end
      if (out_valid && out_ready) sb.check_verdict(out_data);
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
  end

  // Watchdog on cycles in which no beat moves on either side.
  initial begin
    wait (idle_cycles >= IDLE_LIMIT);
    $display("ERROR: no beat moved for %0d cycles", IDLE_LIMIT);
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    int          start_size;
    int          pick;
    int          n;
    real         r;
    sb = new();

    // Vertices before any first vertex run from the reset state.
    push_vertex(32'sd0, 32'sd0, 32'sd3, 32'sd4, 1'b0, 1'b0);
    push_vertex(32'sd0, 32'sd0, -32'sd7, 32'sd2, 1'b0, 1'b1);
    // Single-vertex polygon sitting on the test point.
    push_vertex(32'sd5, 32'sd5, 32'sd5, 32'sd5, 1'b1, 1'b1);
    // Clockwise square on the axes, closed: one turn, zero x offsets.
    push_vertex(32'sd0, 32'sd0, 32'sd0, 32'sd100, 1'b1, 1'b0);
    push_vertex(32'sd0, 32'sd0, 32'sd100, 32'sd0, 1'b0, 1'b0);
    push_vertex(32'sd0, 32'sd0, 32'sd0, -32'sd100, 1'b0, 1'b0);
    push_vertex(32'sd0, 32'sd0, -32'sd100, 32'sd0, 1'b0, 1'b0);
    push_vertex(32'sd0, 32'sd0, 32'sd0, 32'sd100, 1'b0, 1'b1);
    // A vertex after a last vertex keeps adding to that polygon's sum.
    push_vertex(32'sd0, 32'sd0, 32'sd100, 32'sd0, 1'b0, 1'b1);
    // Changes of exactly a half turn, both signs.
    push_vertex(32'sd0, 32'sd0, 32'sd0, 32'sd10, 1'b1, 1'b0);
    push_vertex(32'sd0, 32'sd0, 32'sd0, -32'sd10, 1'b0, 1'b0);
    push_vertex(32'sd0, 32'sd0, 32'sd0, 32'sd10, 1'b0, 1'b1);
    // Extreme coordinates and the widest offsets.
    push_vertex(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, 1'b1, 1'b0);
    push_vertex(COORD_MAX, COORD_MAX, COORD_MIN, COORD_MAX, 1'b0, 1'b0);
    push_vertex(COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN, 1'b0, 1'b0);
    push_vertex(COORD_MIN, COORD_MAX, COORD_MIN, COORD_MIN, 1'b0, 1'b1);
    push_vertex(COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN, 1'b1, 1'b0);
    push_vertex(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MIN, 1'b0, 1'b0);
    push_vertex(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, 1'b0, 1'b1);
    // Counterclockwise square, closed: minus one turn.
    push_vertex(32'sd0, 32'sd0, 32'sd0, 32'sd100, 1'b1, 1'b0);
    push_vertex(32'sd0, 32'sd0, -32'sd100, 32'sd0, 1'b0, 1'b0);
    push_vertex(32'sd0, 32'sd0, 32'sd0, -32'sd100, 1'b0, 1'b0);
    push_vertex(32'sd0, 32'sd0, 32'sd100, 32'sd0, 1'b0, 1'b0);
    push_vertex(32'sd0, 32'sd0, 32'sd0, 32'sd100, 1'b0, 1'b1);
    // Spirals of several turns, both ways.
    add_ring(0.0, 0.0, 4096.0, 3, SPIRAL_TURNS, 1, PT_INSIDE, 1'b1);
    add_ring(0.0, 0.0, 4096.0, 3, SPIRAL_TURNS, -1, PT_INSIDE, 1'b1);

    // Random part: mostly well-formed rings, some noise and broken sequences.
    start_size = vertex_q.size();
    while (vertex_q.size() - start_size < RANDOM_BEATS || rings_made < MIN_RINGS) begin
      pick = $urandom_range(0, 9);
      if (pick <= 7) begin
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(3, 12);
        case ($urandom_range(0, 3))
          0:       r = real'($urandom_range(2, 64));
          1:       r = real'($urandom_range(64, 65536));
          2:       r = real'($urandom_range(65536, 1 << 24));
          default: r = real'($urandom_range(1 << 24, 1 << 28));
        endcase
        pick = $urandom_range(0, 9);
        add_ring((real'($urandom_range(0, 2000000)) - 1000000.0) * 1000.0,
                 (real'($urandom_range(0, 2000000)) - 1000000.0) * 1000.0,
                 r, n, ($urandom_range(0, 5) == 0) ? 2 : 1,
                 ($urandom_range(0, 1) == 0) ? 1 : -1,
                 (pick <= 3) ? PT_INSIDE : (pick <= 6) ? PT_OUTSIDE :
                 (pick <= 8) ? PT_ON_VERTEX : PT_ON_EDGE,
                 $urandom_range(0, 7) != 0);
        rings_made++;
      end else begin
        repeat ($urandom_range(1, 6)) begin
          push_vertex($urandom(), $urandom(), $urandom(), $urandom(),
                      1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        end
      end
    end
    total_beats = vertex_q.size();

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    while (accepted_beats != total_beats) @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run covered %0d vertex beats in %0d polygons, %0d of them random rings.",
             sb.vertices_noted, sb.polygons_started, rings_made);
    $display("Checked %0d winding results, %0d inside, including multi-turn spirals.",
             sb.verdicts_checked, sb.inside_count);
    if (sb.faults == 0 && sb.pending() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Failures: %0d, verdicts left waiting: %0d", sb.faults, sb.pending());
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

`default_nettype wire
